// File: rtl/bottleneck_link_emulator_defines.svh
// Assertion macros shared by the link emulator RTL.
`ifndef BOTTLENECK_LINK_EMULATOR_DEFINES_SVH
`define BOTTLENECK_LINK_EMULATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define BLEM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BLEM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BLEM_ASSERT_IMP(lbl, ante, cons, msg)

`define BLEM_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/blem_pkg.sv
// Types, codes and constants of the bottleneck link emulator.
package blem_pkg;

    localparam int ADDR_W     = 48;
    localparam int TICK_W     = 16;
    localparam int ACKS_W     = 16;
    localparam int OCC_W      = 15;
    localparam int QSIZE_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH_DEF        = 1024;
    localparam int SAMPLES_PER_REPORT_DEF = 20;

    localparam logic [TICK_W-1:0] SERVICE_TICKS_RST = 16'd100;
    localparam logic [TICK_W-1:0] RTT_TICKS_RST     = 16'd10;
    localparam int                QSIZE_RST         = 1024;
    localparam logic [TICK_W-1:0] SAMPLE_TICKS_RST  = 16'd100;

    localparam logic [ACKS_W-1:0] ACKS_MAX = '1;
    localparam logic [OCC_W-1:0]  OCC_MAX  = '1;

    // command queue between front and back, power of two
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SERVICE = 2'd0,
        CFG_RTT     = 2'd1,
        CFG_QSIZE   = 2'd2,
        CFG_SAMPLE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_ACK    = 2'd1,
        KIND_NACK   = 2'd2,
        KIND_REPORT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CMD_DATA    = 2'd0,
        CMD_CONNECT = 2'd1,
        CMD_TICK    = 2'd2
    } t_cmd_kind;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_LOAD   = 2'd1,
        ST_REPORT = 2'd2
    } t_state;

    typedef struct packed {
        logic              operation;
        logic              is_connect;
        logic [ADDR_W-1:0] src_addr;
    } t_in_item;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] dest_addr;
        logic [ACKS_W-1:0] ack_total;
        logic [OCC_W-1:0]  occupancy_sum;
        logic              last;
    } t_out_item;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [ADDR_W-1:0] addr;
    } t_cmd;

endpackage

// File: rtl/bottleneck_link_emulator.sv
// Top level of the bottleneck link emulator.
// Commands are taken on start while busy is low and go through a two-entry command queue
// to the link engine, which retires one command per clock while idle. A tick that dequeues
// from the ring also passes through the load state (registered read of the address
// store), and a tick whose ACK is followed by a report passes through the report state.
// Results leave on the registered o_strobe/o_result after the command queue; o_strobe is
// high for exactly one cycle per result and the receiver cannot stall it. busy rises only
// when the command queue is full. Configuration writes are always taken and belong in
// idle periods; a queue_size write empties the ring.
`include "bottleneck_link_emulator_defines.svh"

module bottleneck_link_emulator import blem_pkg::*; #(
    parameter int QUEUE_DEPTH        = QUEUE_DEPTH_DEF,
    parameter int SAMPLES_PER_REPORT = SAMPLES_PER_REPORT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  t_in_item              i_in,
    output logic                  busy,
    output logic                  o_strobe,
    output t_out_item             o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic w_cmd_valid;
    logic w_cmd_pop;
    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    blem_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_in        (i_in),
        .o_busy      (busy),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_pop       (w_cmd_pop)
    );

    blem_back #(
        .QUEUE_DEPTH        (QUEUE_DEPTH),
        .SAMPLES_PER_REPORT (SAMPLES_PER_REPORT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

// File: rtl/blem_front.sv
// Front end: takes input transfers, classifies them and queues the commands.
`include "bottleneck_link_emulator_defines.svh"

module blem_front import blem_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_in_item i_in,
    output logic     o_busy,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_pop
);

    t_cmd               r_q [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wr, n_wr;
    logic [CMDQ_AW-1:0] r_rd, n_rd;
    logic [CMDQ_AW:0]   r_cnt, n_cnt;
    logic               w_push;
    t_cmd               w_cmd;

    always_comb begin
        w_cmd.addr = i_in.src_addr;
        if (i_in.operation) begin
            w_cmd.kind = CMD_TICK;
        end else if (i_in.is_connect) begin
            w_cmd.kind = CMD_CONNECT;
        end else begin
            w_cmd.kind = CMD_DATA;
        end
    end

    assign o_busy      = (r_cnt == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign w_push      = i_start && !o_busy;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        n_wr  = w_push ? r_wr + CMDQ_AW'(1) : r_wr;
        n_rd  = i_pop ? r_rd + CMDQ_AW'(1) : r_rd;
        n_cnt = r_cnt + (CMDQ_AW+1)'(w_push) - (CMDQ_AW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

    `BLEM_ASSERT_IMP(a_no_pop_empty, i_pop, r_cnt != '0, "pop from empty command queue")

endmodule

// File: rtl/blem_back.sv
// Back end: ring buffer, link service and round-trip timers, sampler and reporting.
`include "bottleneck_link_emulator_defines.svh"

module blem_back import blem_pkg::*; #(
    parameter int QUEUE_DEPTH        = QUEUE_DEPTH_DEF,
    parameter int SAMPLES_PER_REPORT = SAMPLES_PER_REPORT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    input  t_cmd                  i_cmd,
    output logic                  o_cmd_pop,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_strobe,
    output t_out_item             o_result
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int MW = PW + 1;
    localparam int QW = (MW > QSIZE_W) ? MW : QSIZE_W;
    localparam int SW = $clog2(SAMPLES_PER_REPORT + 1);
    localparam int OW = ((PW > OCC_W) ? PW : OCC_W) + 1;
    localparam logic [MW-1:0] MOD_RST =
        MW'((QSIZE_RST > QUEUE_DEPTH) ? QUEUE_DEPTH : QSIZE_RST);

    // configuration
    logic [TICK_W-1:0] r_service_ticks, r_rtt_ticks, r_sample_ticks;
    logic [MW-1:0]     r_modulus;
    logic [QW-1:0]     w_cfg_q;
    logic [MW-1:0]     w_cfg_mod;
    logic              w_flush;

    // ring
    logic [ADDR_W-1:0] r_mem [QUEUE_DEPTH];
    logic [ADDR_W-1:0] r_rd_data;
    logic              w_mem_we, w_rd_en;
    logic [PW-1:0]     w_waddr, w_raddr;
    logic [PW-1:0]     r_wp, n_wp, r_rp, n_rp, r_fill, n_fill;

    // link, sampler, report
    logic [TICK_W-1:0] r_service_timer, n_service_timer;
    logic [TICK_W-1:0] r_rtt_timer, n_rtt_timer;
    logic [ADDR_W-1:0] r_waiting_addr, n_waiting_addr;
    logic              r_waiting_valid, n_waiting_valid;
    logic [ACKS_W-1:0] r_ack_counter, n_ack_counter;
    logic [TICK_W-1:0] r_sample_timer, n_sample_timer;
    logic [SW-1:0]     r_sample_idx, n_sample_idx;
    logic [OCC_W-1:0]  r_occ_acc, n_occ_acc;
    logic [ACKS_W-1:0] r_rep_acks, n_rep_acks;
    logic [OCC_W-1:0]  r_rep_occ, n_rep_occ;
    logic              r_ack_pend, n_ack_pend;
    logic              r_rep_pend, n_rep_pend;
    t_state            r_state, n_state;
    logic              r_strobe, n_strobe;
    t_out_item         r_result, n_result;

    // tick scratch
    logic              w_ack_now, w_ack_deq, w_deq, w_rep;
    logic [PW-1:0]     w_fill_after, w_wnext;
    logic [TICK_W-1:0] w_rtt_inc;
    logic [TICK_W:0]   w_svc_inc, w_smp_inc;
    logic [ACKS_W-1:0] w_acks;
    logic [OW-1:0]     w_occ_sum;
    logic [OCC_W-1:0]  w_occ_new;
    logic [SW-1:0]     w_idx_inc;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p,
                                             input logic [MW-1:0] m);
        logic [MW-1:0] s;
        s = {1'b0, p} + MW'(1);
        return (s >= m) ? '0 : s[PW-1:0];
    endfunction

    always_comb begin
        w_cfg_q = QW'(i_cfg_data[QSIZE_W-1:0]);
        if (w_cfg_q < QW'(2)) begin
            w_cfg_mod = MW'(2);
        end else if (w_cfg_q > QW'(QUEUE_DEPTH)) begin
            w_cfg_mod = MW'(QUEUE_DEPTH);
        end else begin
            w_cfg_mod = w_cfg_q[MW-1:0];
        end
    end

    assign w_flush = i_cfg_we && (i_cfg_index == CFG_QSIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_service_ticks <= SERVICE_TICKS_RST;
            r_rtt_ticks     <= RTT_TICKS_RST;
            r_modulus       <= MOD_RST;
            r_sample_ticks  <= SAMPLE_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SERVICE: r_service_ticks <= i_cfg_data;
                CFG_RTT:     r_rtt_ticks     <= i_cfg_data;
                CFG_QSIZE:   r_modulus       <= w_cfg_mod;
                CFG_SAMPLE:  r_sample_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_wp            = r_wp;
        n_rp            = r_rp;
        n_fill          = r_fill;
        n_service_timer = r_service_timer;
        n_rtt_timer     = r_rtt_timer;
        n_waiting_addr  = r_waiting_addr;
        n_waiting_valid = r_waiting_valid;
        n_ack_counter   = r_ack_counter;
        n_sample_timer  = r_sample_timer;
        n_sample_idx    = r_sample_idx;
        n_occ_acc       = r_occ_acc;
        n_rep_acks      = r_rep_acks;
        n_rep_occ       = r_rep_occ;
        n_ack_pend      = r_ack_pend;
        n_rep_pend      = r_rep_pend;
        n_state         = r_state;
        n_strobe        = 1'b0;
        n_result        = '0;
        o_cmd_pop       = 1'b0;
        w_mem_we        = 1'b0;
        w_rd_en         = 1'b0;
        w_wnext         = f_next(r_wp, r_modulus);
        w_waddr         = w_wnext;
        w_raddr         = f_next(r_rp, r_modulus);
        w_ack_now       = 1'b0;
        w_ack_deq       = 1'b0;
        w_deq           = 1'b0;
        w_rep           = 1'b0;
        w_fill_after    = r_fill;
        w_rtt_inc       = (&r_rtt_timer) ? r_rtt_timer : r_rtt_timer + TICK_W'(1);
        w_svc_inc       = {1'b0, r_service_timer} + (TICK_W+1)'(1);
        w_smp_inc       = {1'b0, r_sample_timer} + (TICK_W+1)'(1);
        w_acks          = r_ack_counter;
        w_occ_sum       = '0;
        w_occ_new       = r_occ_acc;
        w_idx_inc       = r_sample_idx + SW'(1);

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_CONNECT: begin
                            n_strobe           = 1'b1;
                            n_result.kind      = KIND_ACCEPT;
                            n_result.dest_addr = i_cmd.addr;
                            n_result.last      = 1'b1;
                        end
                        CMD_DATA: begin
                            if (w_wnext == r_rp) begin
                                n_strobe           = 1'b1;
                                n_result.kind      = KIND_NACK;
                                n_result.dest_addr = i_cmd.addr;
                                n_result.last      = 1'b1;
                            end else begin
                                w_mem_we = 1'b1;
                                n_wp     = w_wnext;
                                n_fill   = r_fill + PW'(1);
                            end
                        end
                        CMD_TICK: begin
                            // link first
                            if (r_waiting_valid) begin
                                n_rtt_timer = w_rtt_inc;
                                if (w_rtt_inc >= r_rtt_ticks) begin
                                    w_ack_now       = 1'b1;
                                    n_waiting_valid = 1'b0;
                                    n_waiting_addr  = '0;
                                    n_rtt_timer     = '0;
                                    n_service_timer = '0;
                                end
                            end else if (w_svc_inc >= {1'b0, r_service_ticks}) begin
                                n_service_timer = '0;
                                if (r_wp != r_rp) begin
                                    w_deq        = 1'b1;
                                    w_rd_en      = 1'b1;
                                    n_rp         = w_raddr;
                                    w_fill_after = r_fill - PW'(1);
                                    n_fill       = w_fill_after;
                                    n_rtt_timer  = '0;
                                    if (r_rtt_ticks == '0) begin
                                        w_ack_deq = 1'b1;
                                    end else begin
                                        n_waiting_valid = 1'b1;
                                    end
                                end
                            end else begin
                                n_service_timer = w_svc_inc[TICK_W-1:0];
                            end

                            if ((w_ack_now || w_ack_deq) && (r_ack_counter != ACKS_MAX)) begin
                                w_acks = r_ack_counter + ACKS_W'(1);
                            end
                            n_ack_counter = w_acks;

                            // then the sampler
                            if (w_smp_inc >= {1'b0, r_sample_ticks}) begin
                                n_sample_timer = '0;
                                w_occ_sum = OW'(r_occ_acc) + OW'(w_fill_after);
                                w_occ_new = (w_occ_sum > OW'(OCC_MAX)) ? OCC_MAX
                                                                     : w_occ_sum[OCC_W-1:0];
                                if (w_idx_inc >= SW'(SAMPLES_PER_REPORT)) begin
                                    w_rep         = 1'b1;
                                    n_rep_acks    = w_acks;
                                    n_rep_occ     = w_occ_new;
                                    n_ack_counter = '0;
                                    n_occ_acc     = '0;
                                    n_sample_idx  = '0;
                                end else begin
                                    n_occ_acc    = w_occ_new;
                                    n_sample_idx = w_idx_inc;
                                end
                            end else begin
                                n_sample_timer = w_smp_inc[TICK_W-1:0];
                            end

                            if (w_ack_now) begin
                                n_strobe           = 1'b1;
                                n_result.kind      = KIND_ACK;
                                n_result.dest_addr = r_waiting_addr;
                                n_result.last      = !w_rep;
                                n_state            = w_rep ? ST_REPORT : ST_IDLE;
                            end else if (w_deq) begin
                                n_ack_pend = w_ack_deq;
                                n_rep_pend = w_rep;
                                n_state    = ST_LOAD;
                            end else if (w_rep) begin
                                n_strobe               = 1'b1;
                                n_result.kind          = KIND_REPORT;
                                n_result.ack_total     = w_acks;
                                n_result.occupancy_sum = w_occ_new;
                                n_result.last          = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD: begin
                n_waiting_addr = r_ack_pend ? '0 : r_rd_data;
                n_state        = ST_IDLE;
                if (r_ack_pend) begin
                    n_strobe           = 1'b1;
                    n_result.kind      = KIND_ACK;
                    n_result.dest_addr = r_rd_data;
                    n_result.last      = !r_rep_pend;
                    n_state            = r_rep_pend ? ST_REPORT : ST_IDLE;
                end else if (r_rep_pend) begin
                    n_strobe               = 1'b1;
                    n_result.kind          = KIND_REPORT;
                    n_result.ack_total     = r_rep_acks;
                    n_result.occupancy_sum = r_rep_occ;
                    n_result.last          = 1'b1;
                end
            end
            ST_REPORT: begin
                n_strobe               = 1'b1;
                n_result.kind          = KIND_REPORT;
                n_result.ack_total     = r_rep_acks;
                n_result.occupancy_sum = r_rep_occ;
                n_result.last          = 1'b1;
                n_state                = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase

        if (w_flush) begin
            n_wp   = '0;
            n_rp   = '0;
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp            <= '0;
            r_rp            <= '0;
            r_fill          <= '0;
            r_service_timer <= '0;
            r_rtt_timer     <= '0;
            r_waiting_addr  <= '0;
            r_waiting_valid <= 1'b0;
            r_ack_counter   <= '0;
            r_sample_timer  <= '0;
            r_sample_idx    <= '0;
            r_occ_acc       <= '0;
            r_ack_pend      <= 1'b0;
            r_rep_pend      <= 1'b0;
            r_state         <= ST_IDLE;
            r_strobe        <= 1'b0;
        end else begin
            r_wp            <= n_wp;
            r_rp            <= n_rp;
            r_fill          <= n_fill;
            r_service_timer <= n_service_timer;
            r_rtt_timer     <= n_rtt_timer;
            r_waiting_addr  <= n_waiting_addr;
            r_waiting_valid <= n_waiting_valid;
            r_ack_counter   <= n_ack_counter;
            r_sample_timer  <= n_sample_timer;
            r_sample_idx    <= n_sample_idx;
            r_occ_acc       <= n_occ_acc;
            r_ack_pend      <= n_ack_pend;
            r_rep_pend      <= n_rep_pend;
            r_state         <= n_state;
            r_strobe        <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rep_acks <= n_rep_acks;
        r_rep_occ  <= n_rep_occ;
        r_result   <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_waddr] <= i_cmd.addr;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `BLEM_ASSERT_IMP(a_ring_empty, 1'b1, (r_fill == '0) == (r_wp == r_rp), "fill count out of step with pointers")
    `BLEM_ASSERT_IMP(a_load_after_idle, r_state == ST_LOAD, $past(r_state) == ST_IDLE, "address load not preceded by a tick")
    `BLEM_ASSERT_IMP(a_report_last, r_strobe && (r_result.kind == KIND_REPORT), r_result.last, "report not marked last")
    `BLEM_ASSERT_IMP(a_wait_holds_service, r_waiting_valid, r_service_timer == '0, "service timer runs while link busy")

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the bottleneck link emulator: directed table, then random phases.
`timescale 1ns / 100ps

module testbench;
    import blem_pkg::*;

    localparam logic OP_ARRIVAL    = 1'b0;
    localparam logic OP_TICK       = 1'b1;
    localparam int   RANDOM_ITEMS  = 550;
    localparam int   SETTLE_CYCLES = 16;
    localparam int   CYCLE_LIMIT   = 400000;
    localparam logic [ADDR_W-1:0] ADDR_ONES = '1;

    typedef struct {
        bit                    is_cfg;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] val;
        t_in_item              item;
        int unsigned           count;
        bit                    typed;
        t_kind                 want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    t_in_item              i_in        = '0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  busy;
    logic                  o_strobe;
    logic                  o_cfg_ready;
    t_out_item             o_result;

    // link predictor state
    logic [ADDR_W-1:0] ring_addr [QUEUE_DEPTH_DEF];
    int unsigned       wr_pos, rd_pos, fill_level;
    int unsigned       svc_timer, rtt_timer, smp_timer, smp_count;
    int unsigned       ack_count, occ_sum;
    logic [ADDR_W-1:0] held_addr;
    bit                held_valid;
    int unsigned       svc_period, rtt_period, ring_size, smp_period;

    t_out_item   step_replies[$];
    t_out_item   reply_q[$];
    t_row        directed[$];
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    bottleneck_link_emulator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_in        (i_in),
        .busy        (busy),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned ring_modulus();
        if (ring_size < 2) return 2;
        if (ring_size > QUEUE_DEPTH_DEF) return QUEUE_DEPTH_DEF;
        return ring_size;
    endfunction

    function automatic int unsigned ring_next(int unsigned p);
        return (p + 1 >= ring_modulus()) ? 0 : p + 1;
    endfunction

    function automatic void add_reply(t_kind k, logic [ADDR_W-1:0] a, int unsigned acks,
                                      int unsigned occ);
        t_out_item r;
        r.kind          = k;
        r.dest_addr     = a;
        r.ack_total     = ACKS_W'(acks);
        r.occupancy_sum = OCC_W'(occ);
        r.last          = 1'b0;
        step_replies.push_back(r);
    endfunction

    function automatic void release_held();
        add_reply(KIND_ACK, held_addr, 0, 0);
        held_valid = 1'b0;
        held_addr  = '0;
        rtt_timer  = 0;
        svc_timer  = 0;
        if (ack_count < ACKS_MAX) ack_count++;
    endfunction

    function automatic void predict_replies(t_in_item it);
        step_replies.delete();
        if (it.operation == OP_ARRIVAL) begin
            if (it.is_connect) begin
                add_reply(KIND_ACCEPT, it.src_addr, 0, 0);
            end else if (ring_next(wr_pos) == rd_pos) begin
                add_reply(KIND_NACK, it.src_addr, 0, 0);
            end else begin
                wr_pos = ring_next(wr_pos);
                ring_addr[wr_pos] = it.src_addr;
                fill_level++;
            end
        end else begin
            if (held_valid) begin
                if (rtt_timer < 16'hFFFF) rtt_timer++;
                if (rtt_timer >= rtt_period) release_held();
            end else begin
                svc_timer++;
                if (svc_timer >= ((svc_period == 0) ? 1 : svc_period)) begin
                    svc_timer = 0;
                    if (wr_pos != rd_pos) begin
                        rd_pos     = ring_next(rd_pos);
                        held_addr  = ring_addr[rd_pos];
                        held_valid = 1'b1;
                        fill_level--;
                        rtt_timer  = 0;
                        if (rtt_period == 0) release_held();
                    end
                end
            end
            smp_timer++;
            if (smp_timer >= ((smp_period == 0) ? 1 : smp_period)) begin
                smp_timer = 0;
                occ_sum += fill_level;
                if (occ_sum > OCC_MAX) occ_sum = 32'(OCC_MAX);
                smp_count++;
                if (smp_count >= SAMPLES_PER_REPORT_DEF) begin
                    add_reply(KIND_REPORT, '0, ack_count, occ_sum);
                    ack_count = 0;
                    occ_sum   = 0;
                    smp_count = 0;
                end
            end
        end
        if (step_replies.size() != 0) step_replies[step_replies.size()-1].last = 1'b1;
    endfunction

    function automatic t_row blank_row();
        t_row r;
        r.is_cfg = 1'b0;
        r.idx    = CFG_SERVICE;
        r.val    = '0;
        r.item   = '0;
        r.count  = 0;
        r.typed  = 1'b0;
        r.want   = KIND_ACCEPT;
        return r;
    endfunction

    function automatic t_row cfg_row(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        t_row r;
        r        = blank_row();
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    function automatic t_row item_row(logic op, logic conn, logic [ADDR_W-1:0] addr,
                                      int unsigned count, bit typed = 1'b0,
                                      t_kind want = KIND_ACCEPT);
        t_row r;
        r                 = blank_row();
        r.item.operation  = op;
        r.item.is_connect = conn;
        r.item.src_addr   = addr;
        r.count           = count;
        r.typed           = typed;
        r.want            = want;
        return r;
    endfunction

    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned pick;
        pick        = $urandom_range(0, 99);
        it.src_addr = {16'($urandom), 32'($urandom)};
        if ($urandom_range(0, 15) == 0) it.src_addr = '0;
        else if ($urandom_range(0, 15) == 0) it.src_addr = ADDR_ONES;
        it.operation  = (pick < 50) ? OP_ARRIVAL : OP_TICK;
        it.is_connect = (pick < 8) || (pick >= 94);
        return it;
    endfunction

    task automatic note_mismatch(string what, logic [95:0] want, logic [95:0] got);
        mismatches++;
        $display("mismatch %s: expected %0h got %0h", what, want, got);
    endtask

    task automatic idle_sender(int unsigned n);
        if (i_cfg_valid) i_cfg_valid <= 1'b0;
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic quiesce();
        idle_sender(1);
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic issue(t_in_item it, bit typed = 1'b0, t_kind want = KIND_ACCEPT);
        t_out_item r;
        if (i_cfg_valid) i_cfg_valid <= 1'b0;
        start <= 1'b1;
        i_in  <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_replies(it);
        if (typed) begin
            r               = '0;
            r.kind          = want;
            r.dest_addr     = it.src_addr;
            r.last          = 1'b1;
            reply_q.push_back(r);
        end else begin
            foreach (step_replies[k]) reply_q.push_back(step_replies[k]);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        if (!i_cfg_valid) i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SERVICE: svc_period = 32'(val);
            CFG_RTT:     rtt_period = 32'(val);
            CFG_QSIZE: begin
                ring_size  = 32'(val[QSIZE_W-1:0]);
                wr_pos     = 0;
                rd_pos     = 0;
                fill_level = 0;
            end
            CFG_SAMPLE:  smp_period = 32'(val);
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : reply_check
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (reply_q.size() == 0) begin
                note_mismatch("reply with none pending", '0, 96'(o_result));
            end else begin
                want = reply_q.pop_front();
                if (o_result.kind !== want.kind)
                    note_mismatch("kind", 96'(want.kind), 96'(o_result.kind));
                if (o_result.dest_addr !== want.dest_addr)
                    note_mismatch("dest_addr", 96'(want.dest_addr), 96'(o_result.dest_addr));
                if (o_result.ack_total !== want.ack_total)
                    note_mismatch("ack_total", 96'(want.ack_total), 96'(o_result.ack_total));
                if (o_result.occupancy_sum !== want.occupancy_sum)
                    note_mismatch("occupancy_sum", 96'(want.occupancy_sum),
                                  96'(o_result.occupancy_sum));
                if (o_result.last !== want.last)
                    note_mismatch("last", 96'(want.last), 96'(o_result.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[bottleneck_link_emulator] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] fixed_cfg [3][4];
        logic [CFG_DATA_W-1:0] phase_cfg [4];
        int unsigned           rand_done;
        int unsigned           phase;
        int unsigned           phase_len;
        bit                    cfg_open;
        bit                    calm;

        fixed_cfg = '{'{16'd1, 16'd0, 16'd2047, 16'd1},
                      '{16'd4, 16'd3, 16'd5, 16'd2},
                      '{16'd65535, 16'd65535, 16'd1024, 16'd65535}};
        rand_done = 0;
        phase     = 0;
        cfg_open  = 1'b0;

        svc_period = 32'(SERVICE_TICKS_RST);
        rtt_period = 32'(RTT_TICKS_RST);
        ring_size  = QSIZE_RST;
        smp_period = 32'(SAMPLE_TICKS_RST);
        wr_pos     = 0;
        rd_pos     = 0;
        fill_level = 0;
        svc_timer  = 0;
        rtt_timer  = 0;
        smp_timer  = 0;
        smp_count  = 0;
        ack_count  = 0;
        occ_sum    = 0;
        held_addr  = '0;
        held_valid = 1'b0;

        // reset defaults first, then zero registers (service and sample periods treated as 1, ring clamped to 2)
        directed.push_back(item_row(OP_ARRIVAL, 1'b1, '0, 1, 1'b1, KIND_ACCEPT));
        directed.push_back(item_row(OP_ARRIVAL, 1'b1, ADDR_ONES, 1, 1'b1, KIND_ACCEPT));
        directed.push_back(cfg_row(CFG_SERVICE, 16'd0));
        directed.push_back(cfg_row(CFG_RTT, 16'd0));
        directed.push_back(cfg_row(CFG_SAMPLE, 16'd0));
        directed.push_back(cfg_row(CFG_QSIZE, 16'd0));
        directed.push_back(item_row(OP_ARRIVAL, 1'b0, ADDR_ONES, 1));
        directed.push_back(item_row(OP_ARRIVAL, 1'b0, 48'h5A5A_A5A5_0F0F, 1, 1'b1,
                                    KIND_NACK));
        // connect flag on a tick is ignored; ACK leaves in the dequeue tick
        directed.push_back(item_row(OP_TICK, 1'b1, 48'h1234_5678_9ABC, 1));
        directed.push_back(item_row(OP_ARRIVAL, 1'b0, '0, 1));
        directed.push_back(item_row(OP_TICK, 1'b0, '0, 1));
        // twentieth sample brings the report
        directed.push_back(item_row(OP_TICK, 1'b0, '0, 18));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                if (!cfg_open) quiesce();
                write_reg(directed[i].idx, directed[i].val);
                cfg_open = 1'b1;
            end else begin
                cfg_open = 1'b0;
                repeat (directed[i].count) begin
                    if ($urandom_range(0, 99) < 7) idle_sender($urandom_range(1, 5));
                    issue(directed[i].item, directed[i].typed, directed[i].want);
                end
            end
        end

        while (rand_done < RANDOM_ITEMS) begin
            if (phase < 3) begin
                phase_cfg = fixed_cfg[phase];
                phase_len = (phase == 2) ? 25 : $urandom_range(60, 90);
            end else begin
                phase_cfg[0] = 16'($urandom_range(0, 5));
                phase_cfg[1] = 16'($urandom_range(0, 6));
                phase_cfg[2] = ($urandom_range(0, 7) == 0) ? 16'd1024
                                                           : 16'($urandom_range(0, 12));
                phase_cfg[3] = 16'($urandom_range(1, 2));
                phase_len    = $urandom_range(40, 90);
            end
            quiesce();
            for (int r = 0; r < 4; r++) write_reg(t_cfg_idx'(r), phase_cfg[r]);
            repeat (phase_len) begin
                calm = (rand_done >= 200 && rand_done < 330);
                if (!calm && $urandom_range(0, 99) < 7) idle_sender($urandom_range(1, 6));
                issue(random_item());
                rand_done++;
            end
            phase++;
        end

        quiesce();
        if (mismatches == 0) begin
            $display("[bottleneck_link_emulator] OK");
        end else begin
            $display("[bottleneck_link_emulator] ERROR");
        end
        $finish;
    end

endmodule
